[src/bdai_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bounded-degree adjacency insert block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bdai_pkg;

   localparam int ID_W = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK     = 2'd0,
      RSP_DEGREE = 2'd1,
      RSP_FULL   = 2'd2,
      RSP_ZERO   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_SEARCH_DRAIN,
      ST_SCAN_BASE,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_DECIDE,
      ST_ADD_START,
      ST_CLR_START,
      ST_ADD_END,
      ST_CLR_END,
      ST_LINK_BASE,
      ST_LINK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       search_rd;
      logic       scan_rd;
      logic       base_ld;
      logic       base_new;
      logic       add_start;
      logic       add_end;
      logic       clr_wr;
      logic       link_wr;
      logic       out_ld;
      status_type out_code;
   } cmd_type;

   typedef struct packed {
      logic id_zero;
      logic nu_zero;
      logic search_last;
      logic k_last;
      logic s_found;
      logic e_found;
      logic deg_full;
      logic store_full;
      logic out_free;
   } sts_type;

endpackage

[src/bdai_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the adjacency insert block.
// Depends on bdai_pkg for the state, command and status types.
module bdai_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bdai_pkg::sts_type sts,
   output bdai_pkg::cmd_type cmd
);

   bdai_pkg::state_type  state_ff, state_in;
   bdai_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdai_pkg::ST_IDLE;
         code_ff  <= bdai_pkg::RSP_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd          = '0;
      cmd.out_code = code_ff;
      req_tready   = 1'b0;
      case (state_ff)
         bdai_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = bdai_pkg::ST_CHECK;
            end
         end
         bdai_pkg::ST_CHECK: begin
            if (sts.id_zero) begin
               code_in  = bdai_pkg::RSP_ZERO;
               state_in = bdai_pkg::ST_RESULT;
            end else if (sts.nu_zero) begin
               state_in = bdai_pkg::ST_DECIDE;
            end else begin
               state_in = bdai_pkg::ST_SEARCH;
            end
         end
         bdai_pkg::ST_SEARCH: begin
            cmd.search_rd = 1'b1;
            if (sts.search_last) begin
               state_in = bdai_pkg::ST_SEARCH_DRAIN;
            end
         end
         bdai_pkg::ST_SEARCH_DRAIN: begin
            state_in = bdai_pkg::ST_SCAN_BASE;
         end
         bdai_pkg::ST_SCAN_BASE: begin
            if (sts.s_found) begin
               cmd.base_ld = 1'b1;
               state_in    = bdai_pkg::ST_SCAN;
            end else begin
               state_in = bdai_pkg::ST_DECIDE;
            end
         end
         bdai_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.k_last) begin
               state_in = bdai_pkg::ST_SCAN_DRAIN;
            end
         end
         bdai_pkg::ST_SCAN_DRAIN: begin
            state_in = bdai_pkg::ST_DECIDE;
         end
         bdai_pkg::ST_DECIDE: begin
            if (sts.s_found && sts.deg_full) begin
               code_in  = bdai_pkg::RSP_DEGREE;
               state_in = bdai_pkg::ST_RESULT;
            end else if (sts.store_full) begin
               code_in  = bdai_pkg::RSP_FULL;
               state_in = bdai_pkg::ST_RESULT;
            end else if (!sts.s_found) begin
               state_in = bdai_pkg::ST_ADD_START;
            end else if (!sts.e_found) begin
               state_in = bdai_pkg::ST_ADD_END;
            end else begin
               state_in = bdai_pkg::ST_LINK_BASE;
            end
         end
         bdai_pkg::ST_ADD_START: begin
            cmd.add_start = 1'b1;
            cmd.base_ld   = 1'b1;
            cmd.base_new  = 1'b1;
            state_in      = bdai_pkg::ST_CLR_START;
         end
         bdai_pkg::ST_CLR_START: begin
            cmd.clr_wr = 1'b1;
            if (sts.k_last) begin
               state_in = sts.e_found ? bdai_pkg::ST_LINK_BASE : bdai_pkg::ST_ADD_END;
            end
         end
         bdai_pkg::ST_ADD_END: begin
            cmd.add_end  = 1'b1;
            cmd.base_ld  = 1'b1;
            cmd.base_new = 1'b1;
            state_in     = bdai_pkg::ST_CLR_END;
         end
         bdai_pkg::ST_CLR_END: begin
            cmd.clr_wr = 1'b1;
            if (sts.k_last) begin
               state_in = bdai_pkg::ST_LINK_BASE;
            end
         end
         bdai_pkg::ST_LINK_BASE: begin
            cmd.base_ld = 1'b1;
            state_in    = bdai_pkg::ST_LINK;
         end
         bdai_pkg::ST_LINK: begin
            cmd.link_wr = 1'b1;
            code_in     = bdai_pkg::RSP_OK;
            state_in    = bdai_pkg::ST_RESULT;
         end
         bdai_pkg::ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = bdai_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdai_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/bdai_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the adjacency insert block: identifier store, neighbor store,
// search and degree counters and the result register. Depends on bdai_pkg.
module bdai_datapath #(
   parameter int NODES = 64,
   parameter int MAX_NEIGHBORS = 5,
   parameter int RSP_W = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [2*bdai_pkg::ID_W-1:0]       req_tdata,
   input  bdai_pkg::cmd_type                 cmd,
   output bdai_pkg::sts_type                 sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata
);

   localparam int IW = $clog2(NODES);
   localparam int SW = $clog2(NODES + 1);
   localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int DW = $clog2(MAX_NEIGHBORS + 1);
   localparam int AW = $clog2(NODES * MAX_NEIGHBORS);
   localparam int IDW = bdai_pkg::ID_W;

   logic [IDW-1:0] ident_mem [NODES];
   logic [SW-1:0]  nb_mem [NODES*MAX_NEIGHBORS];

   logic [IDW-1:0] sid_ff, eid_ff;
   logic [SW-1:0]  nu_ff, nu_in;
   logic [IW-1:0]  idx_ff;
   logic [KW-1:0]  k_ff;
   logic [SW-1:0]  s_ff, s_in, e_ff, e_in;
   logic [DW-1:0]  deg_ff, deg_in;
   logic [AW-1:0]  base_ff;
   logic           cmp_vld_ff;
   logic [IW-1:0]  cmp_idx_ff;
   logic [IDW-1:0] ident_rd_ff;
   logic           nb_vld_ff;
   logic [SW-1:0]  nb_rd_ff;
   logic           rsp_valid_ff;
   logic [bdai_pkg::STATUS_W-1:0] out_status_ff;
   logic [SW-1:0]  out_s_ff, out_e_ff;
   logic [DW-1:0]  out_deg_ff;

   logic           ident_we;
   logic [IDW-1:0] ident_wdata;
   logic           nb_we;
   logic [AW-1:0]  nb_addr;
   logic [SW-1:0]  nb_wdata;
   logic [SW-1:0]  nu_inc, nu_dec, s_dec, cmp_slot;
   logic [IW-1:0]  base_sel;
   logic [AW-1:0]  base_in;
   logic           need_start, need_end, same_id;
   logic [SW:0]    need_sum;

   assign nu_inc   = nu_ff + SW'(1);
   assign nu_dec   = nu_ff - SW'(1);
   assign s_dec    = s_ff - SW'(1);
   assign cmp_slot = SW'(cmp_idx_ff) + SW'(1);
   assign same_id  = (sid_ff == eid_ff);

   assign ident_we    = cmd.add_start || cmd.add_end;
   assign ident_wdata = cmd.add_start ? sid_ff : eid_ff;

   always_ff @(posedge clock) begin
      if (ident_we) begin
         ident_mem[nu_ff[IW-1:0]] <= ident_wdata;
      end
      ident_rd_ff <= ident_mem[idx_ff];
   end

   assign nb_we    = cmd.clr_wr || cmd.link_wr;
   assign nb_addr  = cmd.link_wr ? (base_ff + AW'(deg_ff)) : (base_ff + AW'(k_ff));
   assign nb_wdata = cmd.link_wr ? e_ff : '0;

   always_ff @(posedge clock) begin
      if (nb_we) begin
         nb_mem[nb_addr] <= nb_wdata;
      end
      nb_rd_ff <= nb_mem[nb_addr];
   end

   assign base_sel = cmd.base_new ? nu_ff[IW-1:0] : s_dec[IW-1:0];
   assign base_in  = AW'(AW'(base_sel) * AW'(MAX_NEIGHBORS));

   always_comb begin
      s_in = s_ff;
      if (cmd.accept) begin
         s_in = '0;
      end else if (cmd.add_start) begin
         s_in = nu_inc;
      end else if (cmp_vld_ff && (ident_rd_ff == sid_ff) && (s_ff == '0)) begin
         s_in = cmp_slot;
      end
   end

   always_comb begin
      e_in = e_ff;
      if (cmd.accept) begin
         e_in = '0;
      end else if ((cmd.add_start && same_id) || cmd.add_end) begin
         e_in = nu_inc;
      end else if (cmp_vld_ff && (ident_rd_ff == eid_ff) && (e_ff == '0)) begin
         e_in = cmp_slot;
      end
   end

   always_comb begin
      deg_in = deg_ff;
      if (cmd.accept) begin
         deg_in = '0;
      end else if (cmd.link_wr || (nb_vld_ff && (nb_rd_ff != '0))) begin
         deg_in = deg_ff + DW'(1);
      end
   end

   assign nu_in = ident_we ? nu_inc : nu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nu_ff        <= '0;
         cmp_vld_ff   <= 1'b0;
         nb_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nu_ff      <= nu_in;
         cmp_vld_ff <= cmd.search_rd;
         nb_vld_ff  <= cmd.scan_rd;
         if (cmd.out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sid_ff <= req_tdata[IDW-1:0];
         eid_ff <= req_tdata[2*IDW-1:IDW];
      end
      if (cmd.accept) begin
         idx_ff <= '0;
      end else if (cmd.search_rd) begin
         idx_ff <= idx_ff + IW'(1);
      end
      if (cmd.base_ld) begin
         k_ff    <= '0;
         base_ff <= base_in;
      end else if (cmd.scan_rd || cmd.clr_wr) begin
         k_ff <= k_ff + KW'(1);
      end
      cmp_idx_ff <= idx_ff;
      s_ff       <= s_in;
      e_ff       <= e_in;
      deg_ff     <= deg_in;
      if (cmd.out_ld) begin
         out_status_ff <= cmd.out_code;
         out_s_ff      <= s_ff;
         out_e_ff      <= e_ff;
         out_deg_ff    <= deg_ff;
      end
   end

   assign need_start = (s_ff == '0);
   assign need_end   = (e_ff == '0) && !(need_start && same_id);
   assign need_sum   = (SW+1)'(nu_ff) + (SW+1)'(need_start) + (SW+1)'(need_end);

   assign sts.id_zero     = (sid_ff == '0) || (eid_ff == '0);
   assign sts.nu_zero     = (nu_ff == '0);
   assign sts.search_last = (idx_ff == nu_dec[IW-1:0]);
   assign sts.k_last      = (k_ff == KW'(MAX_NEIGHBORS - 1));
   assign sts.s_found     = (s_ff != '0);
   assign sts.e_found     = (e_ff != '0);
   assign sts.deg_full    = (deg_ff == DW'(MAX_NEIGHBORS));
   assign sts.store_full  = (need_sum > (SW+1)'(NODES));
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({out_deg_ff, out_e_ff, out_s_ff, out_status_ff});

endmodule

[src/bounded_degree_adjacency_insert.sv]
`timescale 1ns / 1ps
// Top level of the bounded-degree adjacency insert block.
// Instantiates bdai_ctrl and bdai_datapath; uses types from bdai_pkg.
//
//   Channel  Direction  Payload (tdata, lowest bits first)
//   req_*    in         start_id[8], end_id[8]
//   rsp_*    out        status[2], start_slot, end_slot, start_degree
//
// The time from an edge's transfer to its result is set by the linear scan of the
// identifier store, one entry a cycle through its read port, and by the neighbor store,
// one row entry a cycle; an edge with a zero identifier skips both. No clearing pass
// follows reset. A result that waits in the output register does not block the next
// transfer in.
module bounded_degree_adjacency_insert #(
   parameter int NODES = 64,
   parameter int MAX_NEIGHBORS = 5,
   localparam int SLOT_W = $clog2(NODES + 1),
   localparam int DEG_W = $clog2(MAX_NEIGHBORS + 1),
   localparam int RSP_W = ((bdai_pkg::STATUS_W + 2*SLOT_W + DEG_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // start_id, end_id
   input  logic [2*bdai_pkg::ID_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status, start_slot, end_slot, start_degree, zero fill
   output logic [RSP_W-1:0]            rsp_tdata
);

   bdai_pkg::cmd_type cmd;
   bdai_pkg::sts_type sts;

   bdai_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdai_datapath #(
      .NODES         (NODES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .RSP_W         (RSP_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_tvalid || rsp_tready))
      else $error("Result loaded over a result not yet transferred.");

   a_one_edge_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Input ready again right after a transfer.");

   a_link_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.link_wr |-> (sts.s_found && sts.e_found && !sts.deg_full))
      else $error("Neighbor written without a start node with room.");

   a_add_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_start || cmd.add_end) |-> !cmd.link_wr && !cmd.out_ld)
      else $error("Node added in the same cycle as a link or result.");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bounded_degree_adjacency_insert: a clocked driver feeds edges
// from a queue, a graph predictor works out each result, and a clocked monitor checks them.
// Depends on bdai_pkg and the block's RTL only.
module tb_top;

   localparam int NODES = 64;
   localparam int MAX_NEIGHBORS = 5;
   localparam int RANDOM_EDGES = 400;
   localparam int CALM_ITEMS = 50;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [7:0] start_id;
      logic [7:0] end_id;
   } edge_item_type;

   typedef struct packed {
      bdai_pkg::status_type status;
      logic [6:0] start_slot;
      logic [6:0] end_slot;
      logic [2:0] start_degree;
   } edge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   edge_item_type edge_q[$];
   edge_result_type expect_q[$];
   edge_item_type next_edge;
   edge_result_type want;

   logic [7:0] graph_ident [NODES];
   logic [6:0] graph_nbr [NODES][MAX_NEIGHBORS];
   int graph_count = 0;

   int errors = 0;
   int items_total = 0;
   int items_sent = 0;
   int results_seen = 0;
   int send_gap = 0;
   int recv_stall = 0;
   int idle_cycles = 0;

   bounded_degree_adjacency_insert #(
      .NODES(NODES),
      .MAX_NEIGHBORS(MAX_NEIGHBORS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int lookup_node(input logic [7:0] id);
      for (int i = 0; i < graph_count; i++)
         if (graph_ident[i] == id) return i + 1;
      return 0;
   endfunction

   function automatic int node_degree(input int slot);
      int n;
      n = 0;
      if (slot == 0) return 0;
      for (int k = 0; k < MAX_NEIGHBORS; k++)
         if (graph_nbr[slot-1][k] != 0) n++;
      return n;
   endfunction

   function automatic int append_node(input logic [7:0] id);
      graph_ident[graph_count] = id;
      for (int k = 0; k < MAX_NEIGHBORS; k++)
         graph_nbr[graph_count][k] = '0;
      graph_count++;
      return graph_count;
   endfunction

   function automatic edge_result_type insert_edge(input logic [7:0] sid, input logic [7:0] eid);
      edge_result_type r;
      int s;
      int e;
      int need;
      r.status = bdai_pkg::RSP_ZERO;
      r.start_slot = '0;
      r.end_slot = '0;
      r.start_degree = '0;
      if (sid == 0 || eid == 0) return r;
      s = lookup_node(sid);
      e = lookup_node(eid);
      r.start_slot = 7'(s);
      r.end_slot = 7'(e);
      if (s != 0 && node_degree(s) >= MAX_NEIGHBORS) begin
         r.status = bdai_pkg::RSP_DEGREE;
         r.start_degree = 3'(MAX_NEIGHBORS);
         return r;
      end
      need = (s == 0 ? 1 : 0) + (e == 0 ? 1 : 0);
      if (s == 0 && e == 0 && sid == eid) need = 1;
      if (graph_count + need > NODES) begin
         r.status = bdai_pkg::RSP_FULL;
         r.start_degree = 3'(node_degree(s));
         return r;
      end
      if (s == 0) begin
         s = append_node(sid);
         if (sid == eid) e = s;
      end
      if (e == 0) e = append_node(eid);
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
         if (graph_nbr[s-1][k] == 0) begin
            graph_nbr[s-1][k] = 7'(e);
            break;
         end
      end
      r.status = bdai_pkg::RSP_OK;
      r.start_slot = 7'(s);
      r.end_slot = 7'(e);
      r.start_degree = 3'(node_degree(s));
      return r;
   endfunction

   task automatic queue_edge(input logic [7:0] sid, input logic [7:0] eid);
      edge_item_type item;
      item.start_id = sid;
      item.end_id = eid;
      edge_q.push_back(item);
   endtask

   // Most identifiers come from a narrow range so that nodes are hit again and the store fills.
   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 99) < 75) return 8'($urandom_range(1, 72));
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("tb_top: result %0d: %s is %0d, expected %0d", results_seen, what, got, exp_val);
      errors++;
   endtask

   initial begin
      logic [7:0] sid;
      logic [7:0] eid;
      int mode;
      queue_edge(8'd0, 8'd0);
      queue_edge(8'd0, 8'd5);
      queue_edge(8'd5, 8'd0);
      queue_edge(8'd255, 8'd255);
      queue_edge(8'd1, 8'd128);
      queue_edge(8'd1, 8'd128);
      queue_edge(8'd1, 8'd255);
      queue_edge(8'd1, 8'd1);
      queue_edge(8'd1, 8'd7);
      queue_edge(8'd1, 8'd200);
      queue_edge(8'd1, 8'd255);
      queue_edge(8'd200, 8'd1);
      queue_edge(8'd170, 8'd85);
      queue_edge(8'd85, 8'd170);
      queue_edge(8'd128, 8'd127);
      for (int n = 0; n < RANDOM_EDGES; n++) begin
         mode = $urandom_range(0, 19);
         sid = pick_id();
         eid = (mode == 3) ? sid : pick_id();
         if (mode == 0 || mode == 2) sid = 8'd0;
         if (mode == 1 || mode == 2) eid = 8'd0;
         queue_edge(sid, eid);
      end
      items_total = edge_q.size();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (items_sent < items_total || expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expect_q.push_back(insert_edge(req_tdata[7:0], req_tdata[15:8]));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (edge_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (edge_q.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 7) - 1;
               req_tvalid <= 1'b0;
            end else begin
               next_edge = edge_q.pop_front();
               req_tdata <= {next_edge.end_id, next_edge.start_id};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expect_q.size() == 0) begin
               report_mismatch("unexpected transfer, tdata", int'(rsp_tdata), 0);
            end else begin
               want = expect_q.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
               if (rsp_tdata[8:2] != want.start_slot)
                  report_mismatch("start_slot", int'(rsp_tdata[8:2]),
                                  int'(want.start_slot));
               if (rsp_tdata[15:9] != want.end_slot)
                  report_mismatch("end_slot", int'(rsp_tdata[15:9]), int'(want.end_slot));
               if (rsp_tdata[18:16] != want.start_degree)
                  report_mismatch("start_degree", int'(rsp_tdata[18:16]),
                                  int'(want.start_degree));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (items_total - items_sent > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("tb_top: done, errors");
               $finish;
            end
         end
      end
   end

endmodule

[filelist.f]
src/bdai_pkg.sv
src/bdai_ctrl.sv
src/bdai_datapath.sv
src/bounded_degree_adjacency_insert.sv
tb/tb_top.sv
